// ===== sv/eaf_pkg.sv =====
// ----------------------------------------------------------------------------
// eaf_pkg: shared types and constants of the extent allocator
// Status codes, free-table cell commands and sizing defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package eaf_pkg;

  localparam int FREE_SLOTS_DEF = 16;
  localparam int USED_SLOTS_DEF = 32;
  localparam int ADDR_W         = 32;
  localparam int ALIGN_W        = 8;
  localparam int CFG_IDX_W      = 1;
  localparam logic [ALIGN_W-1:0] ALIGN_LIMIT = 8'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_ALIGN  = 3'd1,
    ST_BAD_MODE   = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_NOT_ALLOC  = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_INIT      = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_INSERT    = 3'd3,
    OP_SET_START = 3'd4,
    OP_SET_END   = 3'd5
  } cell_op_t;

  // Command broadcast along the row of free-extent cells.
  typedef struct packed {
    cell_op_t          op;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    logic              v;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== sv/eaf_if.sv =====
// ----------------------------------------------------------------------------
// eaf_if: request and result channels
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none
interface eaf_req_if import eaf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [1:0]         placement_mode;
  logic [ADDR_W-1:0]  request_size;
  logic [ALIGN_W-1:0] alignment;
  logic [ADDR_W-1:0]  free_address;
  modport source (output valid, action, placement_mode, request_size, alignment,
                  free_address, input ready);
  modport sink   (input valid, action, placement_mode, request_size, alignment,
                  free_address, output ready);
endinterface

interface eaf_res_if import eaf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] block_start;
  modport source (output valid, status, block_start, input ready);
  modport sink   (input valid, status, block_start, output ready);
endinterface
`default_nettype wire

// ===== sv/eaf_free_cell.sv =====
// ----------------------------------------------------------------------------
// eaf_free_cell: one free-extent slot
// Holds one extent and shifts to or from its neighbours on command.
// ----------------------------------------------------------------------------
`default_nettype none
module eaf_free_cell import eaf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_cmd_t         cmd,
  input  wire logic              sel,
  input  wire logic              ge_idx,
  input  wire logic              first,
  input  wire logic [ADDR_W-1:0] left_start,
  input  wire logic [ADDR_W-1:0] left_end,
  input  wire logic              left_valid,
  input  wire logic              left_c,
  input  wire logic [ADDR_W-1:0] right_start,
  input  wire logic [ADDR_W-1:0] right_end,
  input  wire logic              right_valid,
  output logic [ADDR_W-1:0]      ext_start,
  output logic [ADDR_W-1:0]      ext_end,
  output logic                   ext_valid,
  output logic                   c_out
);
  logic [ADDR_W-1:0] start_r, start_nxt, end_r, end_nxt;
  logic              valid_r, valid_nxt;

  // The table is packed and sorted, so this flag rises once along the row.
  assign c_out = !valid_r || (start_r >= cmd.s);

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    valid_nxt = valid_r;
    case (cmd.op)
      OP_INIT: begin
        if (first) begin
          start_nxt = cmd.s;
          end_nxt   = cmd.e;
          valid_nxt = cmd.v;
        end else begin
          valid_nxt = 1'b0;
        end
      end
      OP_REMOVE: begin
        if (ge_idx) begin
          start_nxt = right_start;
          end_nxt   = right_end;
          valid_nxt = right_valid;
        end
      end
      OP_INSERT: begin
        if (left_c) begin
          start_nxt = left_start;
          end_nxt   = left_end;
          valid_nxt = left_valid;
        end else if (c_out) begin
          start_nxt = cmd.s;
          end_nxt   = cmd.e;
          valid_nxt = 1'b1;
        end
      end
      OP_SET_START: if (sel) start_nxt = cmd.s;
      OP_SET_END:   if (sel) end_nxt = cmd.e;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

  assign ext_start = start_r;
  assign ext_end   = end_r;
  assign ext_valid = valid_r;
endmodule
`default_nettype wire

// ===== sv/eaf_free_row.sv =====
// ----------------------------------------------------------------------------
// eaf_free_row: sorted table of free extents
// A chain of cells; each cell sees its left and right neighbour.
// ----------------------------------------------------------------------------
`default_nettype none
module eaf_free_row import eaf_pkg::*; #(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cell_cmd_t                     cmd,
  input  wire logic [$clog2(FREE_SLOTS)-1:0] idx,
  output logic [ADDR_W-1:0]                  fr_start [FREE_SLOTS],
  output logic [ADDR_W-1:0]                  fr_end   [FREE_SLOTS],
  output logic [FREE_SLOTS-1:0]              fr_valid
);
  localparam int FIDX_W = $clog2(FREE_SLOTS);

  logic [FREE_SLOTS-1:0] c;

  for (genvar j = 0; j < FREE_SLOTS; j++) begin : g_cell
    logic [ADDR_W-1:0] ls, le, rs, re;
    logic              lv, lc, rv;
    if (j == 0) begin : g_first
      assign ls = '0;
      assign le = '0;
      assign lv = 1'b0;
      assign lc = 1'b0;
    end else begin : g_mid
      assign ls = fr_start[j-1];
      assign le = fr_end[j-1];
      assign lv = fr_valid[j-1];
      assign lc = c[j-1];
    end
    if (j == FREE_SLOTS - 1) begin : g_last
      assign rs = '0;
      assign re = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rs = fr_start[j+1];
      assign re = fr_end[j+1];
      assign rv = fr_valid[j+1];
    end
    eaf_free_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .sel         (idx == FIDX_W'(j)),
      .ge_idx      (FIDX_W'(j) >= idx),
      .first       (j == 0),
      .left_start  (ls),
      .left_end    (le),
      .left_valid  (lv),
      .left_c      (lc),
      .right_start (rs),
      .right_end   (re),
      .right_valid (rv),
      .ext_start   (fr_start[j]),
      .ext_end     (fr_end[j]),
      .ext_valid   (fr_valid[j]),
      .c_out       (c[j])
    );
  end
endmodule
`default_nettype wire

// ===== sv/extent_allocator_first_last_fit.sv =====
// Allocate scans the used table for a free slot, then the free extents for a fit;
// free searches the used table for the address, then scans all free slots for neighbours.
// Throughput: one word at a time; the next word is taken the cycle after its result is
// loaded, unless cfg_we is high in that cycle.
// Reset (synchronous, rst_n low): region base register zero, no free extent, no used block.
// ----------------------------------------------------------------------------
// extent_allocator_first_last_fit: first/last fit extent allocator
// Free extents live in a chain of cells, used blocks in a small memory.
// ----------------------------------------------------------------------------
`default_nettype none
module extent_allocator_first_last_fit import eaf_pkg::*; #(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int USED_SLOTS = USED_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  eaf_req_if.sink                   in_ch,
  eaf_res_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);
  localparam int FIDX_W = $clog2(FREE_SLOTS);
  localparam int UIDX_W = $clog2(USED_SLOTS);
  localparam logic [FIDX_W-1:0] F_LAST = FIDX_W'(FREE_SLOTS - 1);
  localparam logic [UIDX_W-1:0] U_LAST = UIDX_W'(USED_SLOTS - 1);

  typedef enum logic [12:0] {
    S_IDLE     = 13'h0001,
    S_USCAN    = 13'h0002,
    S_FIT      = 13'h0004,
    S_SPLIT    = 13'h0008,
    S_REM      = 13'h0010,
    S_INS_PRE  = 13'h0020,
    S_INS_POST = 13'h0040,
    S_FR_RD    = 13'h0080,
    S_FR_CMP   = 13'h0100,
    S_MSCAN    = 13'h0200,
    S_MERGE    = 13'h0400,
    S_MREM     = 13'h0800,
    S_RESP     = 13'h1000
  } state_t;

  state_t             state_r, state_nxt;
  logic               high_r, high_nxt;
  logic [ADDR_W-1:0]  faddr_r, faddr_nxt;
  logic [ADDR_W:0]    size_r, size_nxt, addr_r, addr_nxt, lb_r, lb_nxt, ub_r, ub_nxt;
  logic [ALIGN_W-1:0] mask_r, mask_nxt;
  logic [UIDX_W-1:0]  u_r, u_nxt;
  logic [FIDX_W-1:0]  i_r, i_nxt, hit_r, hit_nxt, p_r, p_nxt, q_r, q_nxt;
  logic               pre_r, pre_nxt, post_r, post_nxt, pf_r, pf_nxt, qf_r, qf_nxt;
  logic [ADDR_W-1:0]  qe_r, qe_nxt;
  status_t            res_st_r, res_st_nxt;
  logic [ADDR_W-1:0]  res_start_r, res_start_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_st_r, out_st_nxt;
  logic [ADDR_W-1:0]  out_start_r, out_start_nxt;
  logic [ADDR_W-1:0]  base_r;
  logic [USED_SLOTS-1:0] uv_r;
  logic               uv_set, uv_clr;

  logic [ADDR_W-1:0]  used_start_mem [USED_SLOTS];
  logic [ADDR_W-1:0]  used_len_mem   [USED_SLOTS];
  logic [ADDR_W-1:0]  rd_start_r, rd_len_r;

  cell_cmd_t          cmd;
  logic [FIDX_W-1:0]  cmd_idx;
  logic [ADDR_W-1:0]  fr_start [FREE_SLOTS];
  logic [ADDR_W-1:0]  fr_end   [FREE_SLOTS];
  logic [FREE_SLOTS-1:0] fr_valid;

  eaf_free_row #(.FREE_SLOTS(FREE_SLOTS)) u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .idx      (cmd_idx),
    .fr_start (fr_start),
    .fr_end   (fr_end),
    .fr_valid (fr_valid)
  );

  // Fit test on the cell under the scan pointer, plus size rounding, alignment check and region end.
  logic [ADDR_W:0]   cs, ce, mask33, lo_a, hi_a, addr_end;
  logic [ADDR_W+1:0] lo_sum;
  logic              cv, lo_fit, hi_fit, bad_align;
  logic [ADDR_W:0]   rnd, cfg_sum;
  logic [ADDR_W-1:0] cfg_end;

  always_comb begin
    cs       = {1'b0, fr_start[i_r]};
    ce       = {1'b0, fr_end[i_r]};
    cv       = fr_valid[i_r];
    mask33   = {{(ADDR_W + 1 - ALIGN_W){1'b0}}, mask_r};
    lo_a     = (cs + mask33) & ~mask33;
    lo_sum   = {1'b0, lo_a} + {1'b0, size_r};
    lo_fit   = cv && (lo_sum <= {1'b0, ce});
    hi_a     = (ce - size_r) & ~mask33;
    hi_fit   = cv && (ce >= size_r) && (hi_a >= cs);
    addr_end = addr_r + size_r;
    rnd      = ({1'b0, in_ch.request_size} + 33'd3) & ~33'd3;
    bad_align = (in_ch.alignment != '0) &&
                ((in_ch.alignment[1:0] != 2'b00) || (in_ch.alignment > ALIGN_LIMIT) ||
                 ((in_ch.alignment & (in_ch.alignment - 8'd1)) != '0));
    cfg_sum  = {1'b0, base_r} + {1'b0, cfg_data};
    cfg_end  = cfg_sum[ADDR_W] ? '1 : cfg_sum[ADDR_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    high_nxt      = high_r;
    faddr_nxt     = faddr_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    lb_nxt        = lb_r;
    ub_nxt        = ub_r;
    mask_nxt      = mask_r;
    u_nxt         = u_r;
    i_nxt         = i_r;
    hit_nxt       = hit_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    pre_nxt       = pre_r;
    post_nxt      = post_r;
    pf_nxt        = pf_r;
    qf_nxt        = qf_r;
    qe_nxt        = qe_r;
    res_st_nxt    = res_st_r;
    res_start_nxt = res_start_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_start_nxt = out_start_r;
    uv_set        = 1'b0;
    uv_clr        = 1'b0;
    cmd           = '{op: OP_NOP, s: '0, e: '0, v: 1'b0};
    cmd_idx       = '0;

    case (state_r)
      S_IDLE: begin
        if (cfg_we && (cfg_index == CFG_REGION_LENGTH)) begin
          cmd = '{op: OP_INIT, s: base_r, e: cfg_end,
                  v: (cfg_data != '0) && (cfg_end > base_r)};
        end else if (in_ch.valid) begin
          faddr_nxt = in_ch.free_address;
          high_nxt  = in_ch.placement_mode[0];
          size_nxt  = (rnd == '0) ? 33'd4 : rnd;
          mask_nxt  = (in_ch.alignment == '0) ? '0 : in_ch.alignment - 8'd1;
          u_nxt     = '0;
          res_start_nxt = '0;
          if (in_ch.action == ACT_FREE) begin
            state_nxt = S_FR_RD;
          end else if (bad_align) begin
            res_st_nxt = ST_BAD_ALIGN;
            state_nxt  = S_RESP;
          end else if (in_ch.placement_mode[1]) begin
            res_st_nxt = ST_BAD_MODE;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_USCAN;
          end
        end
      end
      S_USCAN: begin
        if (!uv_r[u_r]) begin
          i_nxt     = high_r ? F_LAST : '0;
          state_nxt = S_FIT;
        end else if (u_r == U_LAST) begin
          res_st_nxt = ST_TABLE_FULL;
          state_nxt  = S_RESP;
        end else begin
          u_nxt = u_r + 1'b1;
        end
      end
      S_FIT: begin
        if (high_r ? hi_fit : lo_fit) begin
          addr_nxt  = high_r ? hi_a : lo_a;
          lb_nxt    = cs;
          ub_nxt    = ce;
          hit_nxt   = i_r;
          state_nxt = S_SPLIT;
        end else if (high_r ? (i_r == '0) : (!cv || i_r == F_LAST)) begin
          res_st_nxt = ST_NO_SPACE;
          state_nxt  = S_RESP;
        end else begin
          i_nxt = high_r ? i_r - 1'b1 : i_r + 1'b1;
        end
      end
      S_SPLIT: begin
        pre_nxt  = addr_r > lb_r;
        post_nxt = addr_end < ub_r;
        if ((addr_r > lb_r) && (addr_end < ub_r) && fr_valid[FREE_SLOTS-1]) begin
          res_st_nxt = ST_TABLE_FULL;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        cmd       = '{op: OP_REMOVE, s: '0, e: '0, v: 1'b0};
        cmd_idx   = hit_r;
        state_nxt = S_INS_PRE;
      end
      S_INS_PRE: begin
        if (pre_r) begin
          cmd = '{op: OP_INSERT, s: lb_r[ADDR_W-1:0], e: addr_r[ADDR_W-1:0], v: 1'b1};
        end
        state_nxt = S_INS_POST;
      end
      S_INS_POST: begin
        if (post_r) begin
          cmd = '{op: OP_INSERT, s: addr_end[ADDR_W-1:0], e: ub_r[ADDR_W-1:0], v: 1'b1};
        end
        uv_set        = 1'b1;
        res_st_nxt    = ST_OK;
        res_start_nxt = addr_r[ADDR_W-1:0];
        state_nxt     = S_RESP;
      end
      S_FR_RD: state_nxt = S_FR_CMP;
      S_FR_CMP: begin
        if (uv_r[u_r] && (rd_start_r == faddr_r)) begin
          lb_nxt    = {1'b0, rd_start_r};
          ub_nxt    = {1'b0, rd_start_r} + {1'b0, rd_len_r};
          pf_nxt    = 1'b0;
          qf_nxt    = 1'b0;
          i_nxt     = '0;
          state_nxt = S_MSCAN;
        end else if (u_r == U_LAST) begin
          res_st_nxt = ST_NOT_ALLOC;
          state_nxt  = S_RESP;
        end else begin
          u_nxt     = u_r + 1'b1;
          state_nxt = S_FR_RD;
        end
      end
      S_MSCAN: begin
        if (cv && (ce == lb_r)) begin
          p_nxt  = i_r;
          pf_nxt = 1'b1;
        end
        if (cv && (cs == ub_r)) begin
          q_nxt  = i_r;
          qf_nxt = 1'b1;
          qe_nxt = fr_end[i_r];
        end
        if (i_r == F_LAST) begin
          state_nxt = S_MERGE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_MERGE: begin
        res_st_nxt    = ST_OK;
        res_start_nxt = faddr_r;
        state_nxt     = S_RESP;
        uv_clr        = 1'b1;
        if (pf_r && qf_r) begin
          cmd       = '{op: OP_SET_END, s: '0, e: qe_r, v: 1'b1};
          cmd_idx   = p_r;
          uv_clr    = 1'b0;
          state_nxt = S_MREM;
        end else if (pf_r) begin
          cmd     = '{op: OP_SET_END, s: '0, e: ub_r[ADDR_W-1:0], v: 1'b1};
          cmd_idx = p_r;
        end else if (qf_r) begin
          cmd     = '{op: OP_SET_START, s: lb_r[ADDR_W-1:0], e: '0, v: 1'b1};
          cmd_idx = q_r;
        end else if (fr_valid[FREE_SLOTS-1]) begin
          uv_clr        = 1'b0;
          res_st_nxt    = ST_TABLE_FULL;
          res_start_nxt = '0;
        end else begin
          cmd = '{op: OP_INSERT, s: lb_r[ADDR_W-1:0], e: ub_r[ADDR_W-1:0], v: 1'b1};
        end
      end
      S_MREM: begin
        cmd       = '{op: OP_REMOVE, s: '0, e: '0, v: 1'b0};
        cmd_idx   = q_r;
        uv_clr    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_start_nxt = res_start_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      uv_r        <= '0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == CFG_REGION_BASE)) base_r <= cfg_data;
      if (cfg_we && (cfg_index == CFG_REGION_LENGTH)) begin
        uv_r  <= '0;
      end else if (uv_set) begin
        uv_r[u_r] <= 1'b1;
      end else if (uv_clr) begin
        uv_r[u_r] <= 1'b0;
      end
    end
    high_r      <= high_nxt;
    faddr_r     <= faddr_nxt;
    size_r      <= size_nxt;
    addr_r      <= addr_nxt;
    lb_r        <= lb_nxt;
    ub_r        <= ub_nxt;
    mask_r      <= mask_nxt;
    u_r         <= u_nxt;
    i_r         <= i_nxt;
    hit_r       <= hit_nxt;
    p_r         <= p_nxt;
    q_r         <= q_nxt;
    pre_r       <= pre_nxt;
    post_r      <= post_nxt;
    pf_r        <= pf_nxt;
    qf_r        <= qf_nxt;
    qe_r        <= qe_nxt;
    res_st_r    <= res_st_nxt;
    res_start_r <= res_start_nxt;
    out_st_r    <= out_st_nxt;
    out_start_r <= out_start_nxt;
  end

  // Used-block table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (uv_set) begin
      used_start_mem[u_r] <= addr_r[ADDR_W-1:0];
      used_len_mem[u_r]   <= size_r[ADDR_W-1:0];
    end
    rd_start_r <= used_start_mem[u_r];
    rd_len_r   <= used_len_mem[u_r];
  end

  assign in_ch.ready        = (state_r == S_IDLE) && !cfg_we;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.block_start = out_start_r;

  logic [FREE_SLOTS-1:0] fv_inc;
  assign fv_inc = fr_valid + 1'b1;

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_free_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (fv_inc & fr_valid) == '0) else $error("free extents not packed at low slots");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_slot_free_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_POST) |-> !uv_r[u_r]) else $error("allocating into a used slot");

  a_resp_from_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("result lost on completion");
endmodule
`default_nettype wire
